// ===== hw/rtl/windowed_reservoir_sampler_defines.svh =====
// Assertion helpers for the windowed reservoir sampler.
`ifndef WINDOWED_RESERVOIR_SAMPLER_DEFINES_SVH
`define WINDOWED_RESERVOIR_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WRS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define WRS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/wrs_pkg.sv =====
`default_nettype none
package wrs_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SIZE_W        = 7;
   localparam int SLOT_W        = 6;
   localparam int WORD_W        = 32;

   // t / 60 == (t * MIN_RECIP) >> MIN_SHIFT, exact for any 32-bit t
   localparam logic [31:0] MIN_RECIP = 32'h8888_8889;
   localparam int          MIN_SHIFT = 37;
   localparam int          MIN_W     = 64 - MIN_SHIFT;

   localparam logic [5:0]  DIV_STEPS = 6'd32;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [6:0]  SIZE_RESET = 7'd64;

   localparam logic CSR_RESERVOIR_SIZE = 1'b0;
   localparam logic CSR_START_TIME     = 1'b1;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic SET_ALL = 1'b0;
   localparam logic SET_MIN = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] sec_stamp;
      logic [31:0] payload_word;
      logic [31:0] rand_all_decide;
      logic [31:0] rand_all_index;
      logic [31:0] rand_min_decide;
      logic [31:0] rand_min_index;
      logic        read_set;
      logic [5:0]  read_slot;
   } wrs_req_type;

   typedef struct packed {
      logic        all_stored;
      logic [5:0]  all_slot;
      logic        min_stored;
      logic [5:0]  min_slot;
      logic        old_minute_dropped;
      logic [31:0] read_value;
      logic [31:0] read_time;
      logic        read_valid;
      logic [31:0] read_count;
   } wrs_rsp_type;

   typedef struct packed {
      logic load;
      logic calc_minute;
      logic mem_read;
      logic read_out;
      logic div_go;
      logic div_min;
      logic div_mod;
      logic fill_all;
      logic take_all;
      logic fill_min;
      logic take_min;
      logic commit;
   } wrs_cmd_type;

   typedef struct packed {
      logic is_read;
      logic all_full;
      logic min_full;
      logic min_skip;
      logic div_done;
      logic decide_gt;
   } wrs_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/wrs_div.sv =====
`default_nettype none
module wrs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [32:0] rem_init,
   input  logic [31:0] low,
   input  logic [32:0] dvs,
   output logic        done,
   output logic [31:0] quo,
   output logic [32:0] rem
);
   import wrs_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [33:0] trial;
   logic [33:0] diff;

   // restoring divide, one quotient bit per cycle; rem_init < dvs required
   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = DIV_STEPS;
         rem_in  = rem_init;
         quo_in  = low;
         dvs_in  = dvs;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/wrs_datapath.sv =====
`default_nettype none
module wrs_datapath #(
   parameter int SLOTS = wrs_pkg::SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wrs_pkg::wrs_req_type   req_data,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wdata,
   input  wrs_pkg::wrs_cmd_type   cmd,
   output wrs_pkg::wrs_status_type status,
   output logic                   rsp_valid,
   output wrs_pkg::wrs_rsp_type   rsp_data
);
   import wrs_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   wrs_req_type req_ff;
   wrs_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff;
   logic [6:0]  size_ff;
   logic [31:0] latest_ff;
   logic [31:0] all_cnt_ff;
   logic [31:0] min_cnt_ff;
   logic [MIN_W-1:0] smin_ff, lmin_ff;
   logic        a_st_ff, m_st_ff;
   logic [6:0]  a_slot_ff, m_slot_ff;
   logic [63:0] rd_all_ff, rd_min_ff;

   logic [63:0] all_mem [SLOTS];
   logic [63:0] min_mem [SLOTS];

   logic [63:0] prod_t, prod_l;
   logic [6:0]  size_eff;
   logic        min_later, min_older;
   logic [31:0] min_base;
   logic [31:0] div_cnt;
   logic [32:0] n_val, diff_val;
   logic [64:0] num_val;
   logic [32:0] div_rem_init, div_dvs;
   logic [31:0] div_low, div_quo;
   logic [32:0] div_rem;
   logic        div_done;
   logic [31:0] decide;
   logic [31:0] rd_cnt;
   logic [63:0] rd_word;
   logic        rd_in_range;

   assign prod_t = req_ff.sec_stamp * MIN_RECIP;
   assign prod_l = latest_ff * MIN_RECIP;

   always_comb begin
      size_eff = size_ff;
      if (size_ff == '0) begin
         size_eff = 7'd1;
      end else if (int'(size_ff) > SLOTS) begin
         size_eff = 7'(SLOTS);
      end
   end

   assign min_later = smin_ff > lmin_ff;
   assign min_older = smin_ff < lmin_ff;
   assign min_base  = min_later ? '0 : min_cnt_ff;

   // bound = ((n - size) * (2^32 - 1)) / n, numerator by shift and subtract
   assign div_cnt  = cmd.div_min ? min_base : all_cnt_ff;
   assign n_val    = {1'b0, div_cnt} + 33'd1;
   assign diff_val = n_val - 33'(size_eff);
   assign num_val  = {diff_val, 32'b0} - {32'b0, diff_val};

   assign div_rem_init = cmd.div_mod ? '0 : num_val[64:32];
   assign div_low      = cmd.div_mod ?
                         (cmd.div_min ? req_ff.rand_min_index : req_ff.rand_all_index) :
                         num_val[31:0];
   assign div_dvs      = cmd.div_mod ? 33'(size_eff) : n_val;

   wrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .rem_init (div_rem_init),
      .low      (div_low),
      .dvs      (div_dvs),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   assign decide = cmd.div_min ? req_ff.rand_min_decide : req_ff.rand_all_decide;

   assign status.is_read   = (req_ff.req_type == REQ_READ);
   assign status.all_full  = all_cnt_ff >= 32'(size_eff);
   assign status.min_full  = min_base >= 32'(size_eff);
   assign status.min_skip  = min_older;
   assign status.div_done  = div_done;
   assign status.decide_gt = decide > div_quo;

   // slot stores; never-written entries are don't-care
   always_ff @(posedge clock) begin
      if (cmd.commit && a_st_ff) begin
         all_mem[IW'(a_slot_ff)] <= {req_ff.payload_word, req_ff.sec_stamp};
      end
      if (cmd.mem_read) begin
         rd_all_ff <= all_mem[IW'(req_ff.read_slot)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && m_st_ff) begin
         min_mem[IW'(m_slot_ff)] <= {req_ff.payload_word, req_ff.sec_stamp};
      end
      if (cmd.mem_read) begin
         rd_min_ff <= min_mem[IW'(req_ff.read_slot)];
      end
   end

   assign rd_cnt      = (req_ff.read_set == SET_MIN) ? min_cnt_ff : all_cnt_ff;
   assign rd_word     = (req_ff.read_set == SET_MIN) ? rd_min_ff : rd_all_ff;
   assign rd_in_range = 32'(req_ff.read_slot) < 32'(SLOTS);

   always_comb begin
      rsp_in = '0;
      if (cmd.commit) begin
         rsp_in.all_stored         = a_st_ff;
         rsp_in.all_slot           = a_st_ff ? a_slot_ff[5:0] : '0;
         rsp_in.min_stored         = m_st_ff;
         rsp_in.min_slot           = m_st_ff ? m_slot_ff[5:0] : '0;
         rsp_in.old_minute_dropped = min_older;
      end else if (cmd.read_out) begin
         rsp_in.read_value = rd_in_range ? rd_word[63:32] : '0;
         rsp_in.read_time  = rd_in_range ? rd_word[31:0] : '0;
         rsp_in.read_valid = (32'(req_ff.read_slot) < rd_cnt) &&
                             ({1'b0, req_ff.read_slot} < size_eff);
         rsp_in.read_count = rd_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         latest_ff    <= '0;
         all_cnt_ff   <= '0;
         min_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit || cmd.read_out;
         if (csr_we) begin
            case (csr_index)
               CSR_RESERVOIR_SIZE: size_ff   <= csr_wdata[6:0];
               CSR_START_TIME:     latest_ff <= csr_wdata;
               default:            ;
            endcase
         end
         if (cmd.commit) begin
            all_cnt_ff <= (all_cnt_ff == COUNT_MAX) ? all_cnt_ff : all_cnt_ff + 32'd1;
            if (!min_older) begin
               min_cnt_ff <= (min_base == COUNT_MAX) ? min_base : min_base + 32'd1;
            end
            if (req_ff.sec_stamp > latest_ff) begin
               latest_ff <= req_ff.sec_stamp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_data;
         a_st_ff <= 1'b0;
         m_st_ff <= 1'b0;
      end
      if (cmd.calc_minute) begin
         smin_ff <= prod_t[63:MIN_SHIFT];
         lmin_ff <= prod_l[63:MIN_SHIFT];
      end
      if (cmd.fill_all) begin
         a_st_ff   <= 1'b1;
         a_slot_ff <= all_cnt_ff[6:0];
      end else if (cmd.take_all) begin
         a_st_ff   <= 1'b1;
         a_slot_ff <= div_rem[6:0];
      end
      if (cmd.fill_min) begin
         m_st_ff   <= 1'b1;
         m_slot_ff <= min_base[6:0];
      end else if (cmd.take_min) begin
         m_st_ff   <= 1'b1;
         m_slot_ff <= div_rem[6:0];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/wrs_ctrl.sv =====
`default_nettype none
module wrs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  wrs_pkg::wrs_status_type status,
   output wrs_pkg::wrs_cmd_type    cmd
);
   import wrs_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DECODE = 10'b00_0000_0010,
      ST_RDOUT  = 10'b00_0000_0100,
      ST_ACHK   = 10'b00_0000_1000,
      ST_ABND   = 10'b00_0001_0000,
      ST_AMOD   = 10'b00_0010_0000,
      ST_MCHK   = 10'b00_0100_0000,
      ST_MBND   = 10'b00_1000_0000,
      ST_MMOD   = 10'b01_0000_0000,
      ST_COMMIT = 10'b10_0000_0000
   } wrs_state_type;

   wrs_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_read) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_RDOUT;
            end else begin
               cmd.calc_minute = 1'b1;
               state_in        = ST_ACHK;
            end
         end
         ST_RDOUT: begin
            cmd.read_out = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_ACHK: begin
            if (status.all_full) begin
               cmd.div_go = 1'b1;
               state_in   = ST_ABND;
            end else begin
               cmd.fill_all = 1'b1;
               state_in     = ST_MCHK;
            end
         end
         ST_ABND: begin
            if (status.div_done) begin
               if (status.decide_gt) begin
                  cmd.div_go  = 1'b1;
                  cmd.div_mod = 1'b1;
                  state_in    = ST_AMOD;
               end else begin
                  state_in = ST_MCHK;
               end
            end
         end
         ST_AMOD: begin
            if (status.div_done) begin
               cmd.take_all = 1'b1;
               state_in     = ST_MCHK;
            end
         end
         ST_MCHK: begin
            cmd.div_min = 1'b1;
            if (status.min_skip) begin
               state_in = ST_COMMIT;
            end else if (status.min_full) begin
               cmd.div_go = 1'b1;
               state_in   = ST_MBND;
            end else begin
               cmd.fill_min = 1'b1;
               state_in     = ST_COMMIT;
            end
         end
         ST_MBND: begin
            cmd.div_min = 1'b1;
            if (status.div_done) begin
               if (status.decide_gt) begin
                  cmd.div_go  = 1'b1;
                  cmd.div_mod = 1'b1;
                  state_in    = ST_MMOD;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_MMOD: begin
            cmd.div_min = 1'b1;
            if (status.div_done) begin
               cmd.take_min = 1'b1;
               state_in     = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.div_min = 1'b1;
            cmd.commit  = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/windowed_reservoir_sampler.sv =====
`default_nettype none
// Sequence: a read transaction runs decode, store read and read-out; an add
//   transaction runs decode, per set a fill or up to two divider runs, then commit.
// Throughput: one transaction at a time; busy stays high until the result strobe
//   cycle, so the next start can be taken in that same cycle. Receiver cannot stall.
// Add cost is set by the single shared 32-step restoring divider (bound, then slot).
// Reset: synchronous, clears counts and latest time, size back to 64; stores keep data.
module windowed_reservoir_sampler #(
   parameter int SLOTS = wrs_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  wrs_pkg::wrs_req_type req_data,
   output logic                 rsp_valid,
   output wrs_pkg::wrs_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [31:0]          csr_wdata
);
   import wrs_pkg::*;

   // command and status between sequencer and datapath
   wrs_cmd_type    cmd;
   wrs_status_type status;

   // Sequencer: decode, then per set a skip (older minute only), a direct fill (count
   // below size) or a bound divide followed, if the decide word wins, by a slot modulo.
   wrs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath: counts, latest time, minute compare (reciprocal multiply),
   // the two slot stores, the shared divider and the result register.
   wrs_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/wrs_checker.sv =====
`default_nettype none
`include "windowed_reservoir_sampler_defines.svh"
module wrs_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 rsp_valid,
   input wire wrs_pkg::wrs_rsp_type rsp_data
);
   import wrs_pkg::*;

`WRS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
`WRS_ASSERT_IMP(a_rsp_idle, rsp_valid, !busy, "result strobe while busy")
`WRS_ASSERT_NXT(a_rsp_pulse, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
`WRS_ASSERT_IMP(a_add_no_read, rsp_valid && rsp_data.all_stored, rsp_data.read_count == '0 && !rsp_data.read_valid, "add result carries read fields")
`WRS_ASSERT_IMP(a_drop_excl, rsp_valid && rsp_data.old_minute_dropped, !rsp_data.min_stored, "old-minute sample stored in minute set")

endmodule

bind windowed_reservoir_sampler wrs_checker u_wrs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
